// ===== hw/rtl/mcr_pkg.sv =====
`timescale 1ns / 1ps

package mcr_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 10;

  // Request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_CONT  = 1'b1;

  // Decision constants: initial value is 1 - r (3/2 in integer division), steps add 2x+3 or 2(x-y)+5
  localparam int DEC_INIT    = 3 / 2;
  localparam int DEC_INC_NEG = 3;
  localparam int DEC_INC_POS = 5;

  // Step descriptor queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One step emits eight symmetric pixels
  localparam int PIXELS_PER_STEP = 8;
  localparam int PHASE_W         = $clog2(PIXELS_PER_STEP);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PIXELS_PER_STEP - 1);

  // Per-phase pixel pattern, bit n for phase n:
  //   swap: x coordinate takes the y offset and y coordinate the x offset
  //   neg_x / neg_y: subtract the offset from the center instead of adding
  localparam logic [PIXELS_PER_STEP-1:0] PIX_SWAP  = 8'b1010_1010;
  localparam logic [PIXELS_PER_STEP-1:0] PIX_NEG_X = 8'b1011_0100;
  localparam logic [PIXELS_PER_STEP-1:0] PIX_NEG_Y = 8'b0111_1000;

endpackage

// ===== hw/rtl/mcr_front.sv =====
`timescale 1ns / 1ps

module mcr_front #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic        [RADIUS_BITS-1:0] in_radius,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic        [COORD_BITS-1:0]  push_cx,
  output logic        [COORD_BITS-1:0]  push_cy,
  output logic        [RADIUS_BITS-1:0] push_ox,
  output logic        [RADIUS_BITS-1:0] push_oy,
  output logic                          push_done
);

  localparam int SW = RADIUS_BITS + 2;  // signed offsets, y may reach -1
  localparam int DW = RADIUS_BITS + 3;  // signed decision

  logic                          active_r;
  logic        [RADIUS_BITS-1:0] ox_r;
  logic        [RADIUS_BITS-1:0] oy_r;
  logic signed [DW-1:0]          dec_r;
  logic        [COORD_BITS-1:0]  cx_r;
  logic        [COORD_BITS-1:0]  cy_r;

  logic                 start;
  logic                 do_step;
  logic                 accept;
  logic signed [SW-1:0] x0, y0, x1, y1;
  logic signed [DW-1:0] xe, ye, d0, d1;
  logic                 done;

  always_comb begin
    start   = (in_op == mcr_pkg::OP_START);
    do_step = start || active_r;
    if (start) begin
      x0 = '0;
      y0 = {2'b00, in_radius};
      d0 = DW'(mcr_pkg::DEC_INIT) - {3'b000, in_radius};
    end else begin
      x0 = {2'b00, ox_r};
      y0 = {2'b00, oy_r};
      d0 = dec_r;
    end
    xe = {x0[SW-1], x0};
    ye = {y0[SW-1], y0};
    if (d0[DW-1]) begin
      d1 = d0 + (xe <<< 1) + DW'(mcr_pkg::DEC_INC_NEG);
      y1 = y0;
    end else begin
      d1 = d0 + ((xe - ye) <<< 1) + DW'(mcr_pkg::DEC_INC_POS);
      y1 = y0 - SW'(1);
    end
    x1   = x0 + SW'(1);
    done = (x1 > y1);
  end

  // Continue while idle is taken and dropped
  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && do_step;
  assign push_cx    = start ? in_center_x : cx_r;
  assign push_cy    = start ? in_center_y : cy_r;
  assign push_ox    = x0[RADIUS_BITS-1:0];
  assign push_oy    = y0[RADIUS_BITS-1:0];
  assign push_done  = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ox_r     <= '0;
      oy_r     <= '0;
      dec_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
    end else if (accept && do_step) begin
      active_r <= !done;
      ox_r     <= x1[RADIUS_BITS-1:0];
      oy_r     <= y1[RADIUS_BITS-1:0];
      dec_r    <= d1;
      if (start) begin
        cx_r <= in_center_x;
        cy_r <= in_center_y;
      end
    end
  end

endmodule

// ===== hw/rtl/mcr_queue.sv =====
`timescale 1ns / 1ps

module mcr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int D  = mcr_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  mem_r [D];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign wr_ready = (count_r != CW'(D));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(D - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(D - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mcr_back.sv =====
`timescale 1ns / 1ps

module mcr_back #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic [COORD_BITS-1:0]        q_cx,
  input  logic [COORD_BITS-1:0]        q_cy,
  input  logic [RADIUS_BITS-1:0]       q_ox,
  input  logic [RADIUS_BITS-1:0]       q_oy,
  input  logic                         q_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_pixel_x,
  output logic signed [COORD_BITS:0]   out_pixel_y,
  output logic                         out_last_of_step,
  output logic                         out_circle_done
);

  localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  logic                             busy_r;
  logic [mcr_pkg::PHASE_W-1:0]      phase_r;
  logic [COORD_BITS-1:0]            cx_r;
  logic [COORD_BITS-1:0]            cy_r;
  logic [RADIUS_BITS-1:0]           ox_r;
  logic [RADIUS_BITS-1:0]           oy_r;
  logic                             done_r;

  logic                   last;
  logic                   swap, neg_x, neg_y;
  logic [RADIUS_BITS-1:0] ax, ay;
  logic [SUM_W-1:0]       cxe, cye, axe, aye, sx, sy;

  assign last    = (phase_r == mcr_pkg::LAST_PHASE);
  assign q_ready = !busy_r || (out_ready && last);

  always_comb begin
    swap  = mcr_pkg::PIX_SWAP[phase_r];
    neg_x = mcr_pkg::PIX_NEG_X[phase_r];
    neg_y = mcr_pkg::PIX_NEG_Y[phase_r];
    ax    = swap ? oy_r : ox_r;
    ay    = swap ? ox_r : oy_r;
    cxe   = {{(SUM_W - COORD_BITS){cx_r[COORD_BITS-1]}}, cx_r};
    cye   = {{(SUM_W - COORD_BITS){cy_r[COORD_BITS-1]}}, cy_r};
    axe   = {{(SUM_W - RADIUS_BITS){1'b0}}, ax};
    aye   = {{(SUM_W - RADIUS_BITS){1'b0}}, ay};
    sx    = neg_x ? (cxe - axe) : (cxe + axe);
    sy    = neg_y ? (cye - aye) : (cye + aye);
  end

  assign out_valid        = busy_r;
  assign out_pixel_x      = sx[COORD_BITS:0];
  assign out_pixel_y      = sy[COORD_BITS:0];
  assign out_last_of_step = last;
  assign out_circle_done  = last && done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= '0;
    end else if (q_ready) begin
      busy_r  <= q_valid;
      phase_r <= '0;
    end else if (out_ready) begin
      phase_r <= phase_r + mcr_pkg::PHASE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cx_r   <= q_cx;
      cy_r   <= q_cy;
      ox_r   <= q_ox;
      oy_r   <= q_oy;
      done_r <= q_done;
    end
  end

endmodule

// ===== hw/rtl/midpoint_circle_rasterizer_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     in_op, in_center_x, in_center_y, in_radius
// out      output     out_valid / out_ready   out_pixel_x, out_pixel_y, out_last_of_step,
//                                             out_circle_done
//
// A step request yields eight pixel results at one pixel per cycle while out_ready
// is high; the pixel serializer paces a sustained stream, and the front takes new
// requests while the back is still serializing. A request is taken when the step queue has room.
// Synchronous active-low reset clears the circle state and empties the queue.
// Output stalls fill the two-entry step queue; input stalls leave the back running.
module midpoint_circle_rasterizer_top #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic        [RADIUS_BITS-1:0] in_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS:0]    out_pixel_x,
  output logic signed [COORD_BITS:0]    out_pixel_y,
  output logic                          out_last_of_step,
  output logic                          out_circle_done
);

  // Step descriptor: center, offsets before the step, finish flag
  localparam int QW = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

  logic                   push_valid, push_ready;
  logic [COORD_BITS-1:0]  push_cx, push_cy;
  logic [RADIUS_BITS-1:0] push_ox, push_oy;
  logic                   push_done;

  logic                   q_valid, q_ready;
  logic [QW-1:0]          q_data;

  // Front: take requests, drop continues with no circle in progress, run the
  // decision update and hand one descriptor per step to the queue.
  mcr_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius  (in_radius),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cx    (push_cx),
    .push_cy    (push_cy),
    .push_ox    (push_ox),
    .push_oy    (push_oy),
    .push_done  (push_done)
  );

  // Hold pending steps so front and back stall independently
  mcr_queue #(
    .W(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_data ({push_cx, push_cy, push_ox, push_oy, push_done}),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_data)
  );

  // Back: walk the eight symmetric pixels of each step, flag the last one
  mcr_back #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_cx            (q_data[QW-1 -: COORD_BITS]),
    .q_cy            (q_data[QW-1-COORD_BITS -: COORD_BITS]),
    .q_ox            (q_data[2*RADIUS_BITS : RADIUS_BITS+1]),
    .q_oy            (q_data[RADIUS_BITS:1]),
    .q_done          (q_data[0]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_last_of_step(out_last_of_step),
    .out_circle_done (out_circle_done)
  );

endmodule

// ===== hw/rtl/mcr_checker.sv =====
`timescale 1ns / 1ps

module mcr_checker #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_BITS:0]    out_pixel_x,
  input logic signed [COORD_BITS:0]    out_pixel_y,
  input logic                          out_last_of_step,
  input logic                          out_circle_done
);

  // Finish flag only rides on the last pixel of a step
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_circle_done) |-> out_last_of_step)
    else $error("circle_done without last_of_step");

  // Stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
       && $stable(out_last_of_step) && $stable(out_circle_done)))
    else $error("stalled pixel changed");

  // Pixels of one step come without gaps
  a_step_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_step) |=> out_valid)
    else $error("gap inside a step");

  // A new step never opens on its last pixel
  a_step_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_step) |=> !(out_valid && out_last_of_step))
    else $error("step shorter than eight pixels");

  // Start on an idle output shows pixels once the step queue and the back have registered it
  a_start_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == mcr_pkg::OP_START) && !out_valid) |=> ##1 out_valid)
    else $error("start did not produce pixels");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker #(
  .COORD_BITS (COORD_BITS)
) u_mcr_checker (.*);
